@@ rtl/vrpb_pkg.sv @@
// Shared types, codes and constants for the volume Radon projection binner.
// Used by vrpb_cordic and volume_radon_projection_binner; depends on nothing.
package vrpb_pkg;

    // Default sizes, handed to the top level parameters.
    localparam int MAX_DIM_DEF   = 64;
    localparam int MAX_THETA_DEF = 64;
    localparam int MAX_PHI_DEF   = 128;
    localparam int SUM_WIDTH_DEF = 48;

    // Configuration register indexes.
    localparam logic [2:0] CFG_DIM_X       = 3'd0;
    localparam logic [2:0] CFG_DIM_Y       = 3'd1;
    localparam logic [2:0] CFG_DIM_Z       = 3'd2;
    localparam logic [2:0] CFG_THETA_COUNT = 3'd3;
    localparam logic [2:0] CFG_PHI_COUNT   = 3'd4;
    localparam logic [2:0] CFG_THETA_STEP  = 3'd5;
    localparam logic [2:0] CFG_PHI_STEP    = 3'd6;
    localparam int         CFG_IDX_W       = 3;
    localparam int         CFG_DATA_W      = 19;

    // Request codes. The spare code is accepted and ignored.
    localparam logic [1:0] REQ_ACCUM = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_SPARE = 2'd3;

    // Angles are unsigned Q16 radians, reduced below two pi.
    localparam int                ANG_W       = 19;
    localparam logic [ANG_W-1:0]  TWO_PI_Q16  = 19'd411775;
    localparam int                PI_Q16      = 205887;
    localparam int                HALF_PI_Q16 = 102944;

    // CORDIC datapath: Q30 values carried in 34 bits, results in 32 bits.
    localparam int CORDIC_STEPS = 24;
    localparam int CX_W         = 34;
    localparam int TRIG_W       = 32;
    localparam logic signed [CX_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [CX_W-1:0] ATAN_Q30 [CORDIC_STEPS] = '{
        34'sh03243F6A8, 34'sh01DAC6705, 34'sh00FADBAFC, 34'sh007F56EA6,
        34'sh003FEAB76, 34'sh001FFD55B, 34'sh000FFFAAA, 34'sh0007FFF55,
        34'sh0003FFFEA, 34'sh0001FFFFD, 34'sh0000FFFFF, 34'sh00007FFFF,
        34'sh00003FFFF, 34'sh00001FFFF, 34'sh00000FFFF, 34'sh000007FFF,
        34'sh000003FFF, 34'sh000001FFF, 34'sh000000FFF, 34'sh0000007FF,
        34'sh0000003FF, 34'sh0000001FF, 34'sh0000000FF, 34'sh00000007F
    };

    typedef struct packed {
        logic [1:0]         req_type;
        logic [5:0]         voxel_x;
        logic [5:0]         voxel_y;
        logic [5:0]         voxel_z;
        logic signed [31:0] voxel_value;
        logic [5:0]         bin_p;
        logic [5:0]         bin_theta;
        logic [6:0]         bin_phi;
    } t_req;

    typedef struct packed {
        logic signed [47:0] bin_sum;
        logic               bad_index;
    } t_res;

    typedef struct packed {
        logic                     done;
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } t_cordic_res;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TH_GO,
        ST_TH_WAIT,
        ST_PH_GO,
        ST_PH_WAIT,
        ST_YSP,
        ST_TRD,
        ST_MU,
        ST_MW,
        ST_D1,
        ST_D2,
        ST_BIN,
        ST_ACC,
        ST_RD_ISSUE,
        ST_RD_DATA
    } t_state;

endpackage

@@ rtl/vrpb_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; no package dependency.
module vrpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/vrpb_cordic.sv @@
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, 24 in all.
// Depends on vrpb_pkg for angle constants, the arctangent table and result type.
module vrpb_cordic (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_go,
    input  logic [vrpb_pkg::ANG_W-1:0]       i_angle,
    output vrpb_pkg::t_cordic_res            o_res
);

    localparam int RS_W = vrpb_pkg::ANG_W + 2;
    localparam int CX_W = vrpb_pkg::CX_W;

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [4:0]             r_i, n_i;
    logic signed [CX_W-1:0] r_x, n_x, r_y, n_y, r_z, n_z;
    logic                   r_neg, n_neg;

    logic signed [RS_W-1:0] rs;
    logic signed [CX_W-1:0] sx, sy;
    logic                   fneg;

    always_comb begin
        // Fold the angle into [-pi/2, pi/2]; the fold negates both results.
        rs   = $signed(RS_W'(i_angle));
        fneg = 1'b0;
        if (rs > RS_W'(vrpb_pkg::PI_Q16)) begin
            rs = rs - $signed(RS_W'(vrpb_pkg::TWO_PI_Q16));
        end
        if (rs > RS_W'(vrpb_pkg::HALF_PI_Q16)) begin
            rs   = rs - RS_W'(vrpb_pkg::PI_Q16);
            fneg = 1'b1;
        end else if (rs < -RS_W'(vrpb_pkg::HALF_PI_Q16)) begin
            rs   = rs + RS_W'(vrpb_pkg::PI_Q16);
            fneg = 1'b1;
        end

        sx = r_x >>> r_i;
        sy = r_y >>> r_i;

        n_busy = r_busy;
        n_done = 1'b0;
        n_i    = r_i;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_neg  = r_neg;

        if (i_go) begin
            n_busy = 1'b1;
            n_i    = '0;
            n_x    = vrpb_pkg::CORDIC_GAIN_Q30;
            n_y    = '0;
            n_z    = CX_W'(rs) <<< 14;
            n_neg  = fneg;
        end else if (r_busy) begin
            if (!r_z[CX_W-1]) begin
                n_x = r_x - sy;
                n_y = r_y + sx;
                n_z = r_z - vrpb_pkg::ATAN_Q30[r_i];
            end else begin
                n_x = r_x + sy;
                n_y = r_y - sx;
                n_z = r_z + vrpb_pkg::ATAN_Q30[r_i];
            end
            n_i = r_i + 5'd1;
            if (r_i == 5'(vrpb_pkg::CORDIC_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_i   <= n_i;
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_neg <= n_neg;
    end

    assign o_res.done  = r_done;
    assign o_res.cos_v = vrpb_pkg::TRIG_W'(r_neg ? -r_x : r_x);
    assign o_res.sin_v = vrpb_pkg::TRIG_W'(r_neg ? -r_y : r_y);

endmodule

@@ rtl/volume_radon_projection_binner.sv @@
// Top level of the volume Radon projection binner: sequencer, shared multiplier,
// angle stepping and the bin store. Depends on vrpb_pkg, vrpb_ram and vrpb_cordic.
//
//  Channel   | Ports                               | Handshake
//  ----------+-------------------------------------+----------------------------------
//  request   | start, busy, i_req                  | item taken when start && !busy
//  result    | o_valid, o_res                      | one-cycle strobe, cannot be held
//  config    | i_cfg_we, i_cfg_idx, i_cfg_data     | written on any edge with i_cfg_we
//
// An accumulate item runs the 24-step CORDIC once per theta and per phi angle, and the
// per-bin sequence of up to seven steps around one shared multiplier for each theta in
// each phi; a read item with a valid index passes RD_ISSUE and RD_DATA, a clear item
// zeroes one store entry per cycle. After reset the block first zeroes the store, one
// entry a cycle (2^19 entries at default sizes), with busy high; config writes are
// still taken. The result strobe is never stalled, so nothing backs up behind it.
module volume_radon_projection_binner #(
    parameter int MAX_DIM   = vrpb_pkg::MAX_DIM_DEF,
    parameter int MAX_THETA = vrpb_pkg::MAX_THETA_DEF,
    parameter int MAX_PHI   = vrpb_pkg::MAX_PHI_DEF,
    parameter int SUM_WIDTH = vrpb_pkg::SUM_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  vrpb_pkg::t_req                    i_req,
    output logic                              o_valid,
    output vrpb_pkg::t_res                    o_res,
    input  logic                              i_cfg_we,
    input  logic [vrpb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [vrpb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // Index widths of the store: phi, theta and projection offset are concatenated.
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int PW    = $clog2(MAX_DIM);
    localparam int TW    = (MAX_THETA > 1) ? $clog2(MAX_THETA) : 1;
    localparam int FW    = (MAX_PHI > 1) ? $clog2(MAX_PHI) : 1;
    localparam int TCW   = $clog2(MAX_THETA + 1);
    localparam int FCW   = $clog2(MAX_PHI + 1);
    localparam int AW    = FW + TW + PW;
    localparam int DEPTH = 1 << AW;
    localparam int CW    = ((DW > 6) ? DW : 6) + 2;
    localparam int DDW   = 48;
    localparam int PSW   = 18;
    localparam int SW1   = SUM_WIDTH + 1;
    localparam int AGW   = vrpb_pkg::ANG_W;
    localparam int TRW   = vrpb_pkg::TRIG_W;

    // Configuration registers.
    logic [6:0]  r_cfg_dim_x, r_cfg_dim_y, r_cfg_dim_z, r_cfg_tc;
    logic [7:0]  r_cfg_pc;
    logic [17:0] r_cfg_tstep;
    logic [18:0] r_cfg_pstep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_dim_x <= 7'd64;
            r_cfg_dim_y <= 7'd64;
            r_cfg_dim_z <= 7'd64;
            r_cfg_tc    <= 7'd64;
            r_cfg_pc    <= 8'd128;
            r_cfg_tstep <= 18'd3217;
            r_cfg_pstep <= 19'd3217;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vrpb_pkg::CFG_DIM_X:       r_cfg_dim_x <= i_cfg_data[6:0];
                vrpb_pkg::CFG_DIM_Y:       r_cfg_dim_y <= i_cfg_data[6:0];
                vrpb_pkg::CFG_DIM_Z:       r_cfg_dim_z <= i_cfg_data[6:0];
                vrpb_pkg::CFG_THETA_COUNT: r_cfg_tc    <= i_cfg_data[6:0];
                vrpb_pkg::CFG_PHI_COUNT:   r_cfg_pc    <= i_cfg_data[7:0];
                vrpb_pkg::CFG_THETA_STEP:  r_cfg_tstep <= i_cfg_data[17:0];
                vrpb_pkg::CFG_PHI_STEP:    r_cfg_pstep <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A zero dimension acts as one; oversized dimensions clamp to the store size.
    function automatic logic [DW-1:0] f_eff_dim(input logic [6:0] v);
        if (v == 7'd0) begin
            return DW'(1);
        end else if (32'(v) > MAX_DIM) begin
            return DW'(MAX_DIM);
        end else begin
            return DW'(v);
        end
    endfunction

    // Both operands are below two pi, so one conditional subtract reduces the sum.
    function automatic logic [AGW-1:0] f_ang_add(input logic [AGW-1:0] a,
                                                 input logic [AGW-1:0] s);
        logic [AGW:0] v;
        v = {1'b0, a} + {1'b0, s};
        if (v >= {1'b0, vrpb_pkg::TWO_PI_Q16}) begin
            v = v - {1'b0, vrpb_pkg::TWO_PI_Q16};
        end
        return AGW'(v);
    endfunction

    function automatic logic [AGW-1:0] f_red_step(input logic [AGW-1:0] s);
        return (s >= vrpb_pkg::TWO_PI_Q16) ? (s - vrpb_pkg::TWO_PI_Q16) : s;
    endfunction

    logic [DW-1:0]    dx, dy, dz, maxd, cout;
    logic [TCW-1:0]   tc;
    logic [FCW-1:0]   pc;
    logic [AGW-1:0]   tstep, pstep;

    always_comb begin
        dx    = f_eff_dim(r_cfg_dim_x);
        dy    = f_eff_dim(r_cfg_dim_y);
        dz    = f_eff_dim(r_cfg_dim_z);
        maxd  = (dx > dy) ? dx : dy;
        maxd  = (dz > maxd) ? dz : maxd;
        cout  = (maxd - DW'(1)) >> 1;
        tc    = (32'(r_cfg_tc) > MAX_THETA) ? TCW'(MAX_THETA) : TCW'(r_cfg_tc);
        pc    = (32'(r_cfg_pc) > MAX_PHI) ? FCW'(MAX_PHI) : FCW'(r_cfg_pc);
        tstep = f_red_step(AGW'(r_cfg_tstep));
        pstep = f_red_step(r_cfg_pstep);
    end

    // Sequencer registers.
    vrpb_pkg::t_state          r_state, n_state;
    vrpb_pkg::t_req            r_req, n_req;
    logic [AW-1:0]             r_clr, n_clr;
    logic [TCW-1:0]            r_t, n_t;
    logic [FCW-1:0]            r_f, n_f;
    logic [AGW-1:0]            r_ang, n_ang, r_pang, n_pang;
    logic signed [TRW-1:0]     r_cp, n_cp, r_sp, n_sp, r_u, n_u, r_w, n_w;
    logic signed [DDW-1:0]     r_d, n_d, r_ysp, n_ysp;
    logic [AW-1:0]             r_addr, n_addr;
    logic                      r_valid, n_valid;
    vrpb_pkg::t_res            r_res, n_res;

    // Centred voxel coordinates of the item being worked on.
    logic signed [CW-1:0] xc, yc, zc;
    always_comb begin
        xc = $signed(CW'(r_req.voxel_x)) - $signed(CW'((dx - DW'(1)) >> 1));
        yc = $signed(CW'(r_req.voxel_y)) - $signed(CW'((dy - DW'(1)) >> 1));
        zc = $signed(CW'(r_req.voxel_z)) - $signed(CW'((dz - DW'(1)) >> 1));
    end

    // Theta table: cosine and sine of each theta angle, refilled per voxel.
    logic                   th_we;
    logic [2*TRW-1:0]       th_wdata, th_rdata;
    logic signed [TRW-1:0]  th_ct, th_st;

    vrpb_ram #(.WIDTH(2 * TRW), .DEPTH(MAX_THETA)) u_theta_ram (
        .i_clk  (i_clk),
        .i_we   (th_we),
        .i_waddr(r_t[TW-1:0]),
        .i_wdata(th_wdata),
        .i_raddr(r_t[TW-1:0]),
        .o_rdata(th_rdata)
    );

    assign th_ct = $signed(th_rdata[2*TRW-1:TRW]);
    assign th_st = $signed(th_rdata[TRW-1:0]);

    // Bin store.
    logic                 m_we;
    logic [AW-1:0]        m_waddr, m_raddr;
    logic [SUM_WIDTH-1:0] m_wdata, m_rdata;

    vrpb_ram #(.WIDTH(SUM_WIDTH), .DEPTH(DEPTH)) u_bin_ram (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_waddr(m_waddr),
        .i_wdata(m_wdata),
        .i_raddr(m_raddr),
        .o_rdata(m_rdata)
    );

    // Shared CORDIC for theta and phi angles.
    logic                  cor_go;
    logic [AGW-1:0]        cor_angle;
    vrpb_pkg::t_cordic_res cor_res;

    vrpb_cordic u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (cor_go),
        .i_angle(cor_angle),
        .o_res  (cor_res)
    );

    // The one multiplier, time-shared by the projection steps.
    logic signed [TRW-1:0]   mul_a, mul_b;
    logic signed [2*TRW-1:0] prod;

    always_comb begin
        unique case (r_state)
            vrpb_pkg::ST_YSP: begin
                mul_a = TRW'(yc);
                mul_b = r_sp;
            end
            vrpb_pkg::ST_MU: begin
                mul_a = th_ct;
                mul_b = r_cp;
            end
            vrpb_pkg::ST_MW: begin
                mul_a = th_st;
                mul_b = r_cp;
            end
            vrpb_pkg::ST_D1: begin
                mul_a = TRW'(xc);
                mul_b = r_u;
            end
            vrpb_pkg::ST_D2: begin
                mul_a = TRW'(zc);
                mul_b = r_w;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    // Bin offset: round to nearest by adding one half and flooring, then recentre.
    logic signed [DDW-1:0] rnd;
    logic signed [PSW-1:0] pbin;
    logic                  pbin_ok;
    logic [AW-1:0]         acc_addr, rd_addr;
    logic                  rd_bad;

    always_comb begin
        rnd      = r_d + (DDW'(1) <<< 29);
        pbin     = PSW'(rnd >>> 30) + $signed(PSW'(cout));
        pbin_ok  = !pbin[PSW-1] && (pbin < $signed(PSW'(maxd)));
        acc_addr = {r_f[FW-1:0], r_t[TW-1:0], PW'(pbin)};
        rd_addr  = {FW'(r_req.bin_phi), TW'(r_req.bin_theta), PW'(r_req.bin_p)};
        rd_bad   = (32'(i_req.bin_p) >= 32'(maxd)) || (32'(i_req.bin_theta) >= 32'(tc))
                   || (32'(i_req.bin_phi) >= 32'(pc));
    end

    // Saturating add of the voxel value onto the stored sum.
    logic signed [SW1-1:0]       sum_ext;
    logic [SUM_WIDTH-1:0]        sat_sum;

    always_comb begin
        sum_ext = $signed({m_rdata[SUM_WIDTH-1], m_rdata}) + SW1'(r_req.voxel_value);
        if (sum_ext[SW1-1] != sum_ext[SW1-2]) begin
            sat_sum = sum_ext[SW1-1] ? {1'b1, {(SUM_WIDTH - 1){1'b0}}}
                                     : {1'b0, {(SUM_WIDTH - 1){1'b1}}};
        end else begin
            sat_sum = SUM_WIDTH'(sum_ext);
        end
    end

    // Next state and datapath control.
    logic last_t, last_f;

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_clr   = r_clr;
        n_t     = r_t;
        n_f     = r_f;
        n_ang   = r_ang;
        n_pang  = r_pang;
        n_cp    = r_cp;
        n_sp    = r_sp;
        n_u     = r_u;
        n_w     = r_w;
        n_d     = r_d;
        n_ysp   = r_ysp;
        n_addr  = r_addr;
        n_valid = 1'b0;
        n_res   = r_res;

        th_we     = 1'b0;
        th_wdata  = {cor_res.cos_v, cor_res.sin_v};
        cor_go    = 1'b0;
        cor_angle = r_ang;
        m_we      = 1'b0;
        m_waddr   = r_addr;
        m_wdata   = sat_sum;
        m_raddr   = acc_addr;

        last_t = ((r_t + TCW'(1)) == tc);
        last_f = ((r_f + FCW'(1)) == pc);

        unique case (r_state)
            vrpb_pkg::ST_CLEAR: begin
                m_we    = 1'b1;
                m_waddr = r_clr;
                m_wdata = '0;
                n_clr   = r_clr + AW'(1);
                if (&r_clr) begin
                    n_state = vrpb_pkg::ST_IDLE;
                end
            end
            vrpb_pkg::ST_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    priority case (i_req.req_type)
                        vrpb_pkg::REQ_ACCUM: begin
                            // A voxel outside the volume, or no angles at all, adds nothing.
                            if ((32'(i_req.voxel_x) < 32'(dx))
                                && (32'(i_req.voxel_y) < 32'(dy))
                                && (32'(i_req.voxel_z) < 32'(dz))
                                && (tc != '0) && (pc != '0)) begin
                                n_t     = '0;
                                n_ang   = '0;
                                n_state = vrpb_pkg::ST_TH_GO;
                            end
                        end
                        vrpb_pkg::REQ_READ: begin
                            if (rd_bad) begin
                                n_valid           = 1'b1;
                                n_res.bin_sum     = '0;
                                n_res.bad_index   = 1'b1;
                            end else begin
                                n_state = vrpb_pkg::ST_RD_ISSUE;
                            end
                        end
                        vrpb_pkg::REQ_CLEAR: begin
                            n_clr   = '0;
                            n_state = vrpb_pkg::ST_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            vrpb_pkg::ST_TH_GO: begin
                cor_go  = 1'b1;
                n_state = vrpb_pkg::ST_TH_WAIT;
            end
            vrpb_pkg::ST_TH_WAIT: begin
                if (cor_res.done) begin
                    th_we = 1'b1;
                    n_ang = f_ang_add(r_ang, tstep);
                    if (last_t) begin
                        n_f     = '0;
                        n_pang  = '0;
                        n_state = vrpb_pkg::ST_PH_GO;
                    end else begin
                        n_t     = r_t + TCW'(1);
                        n_state = vrpb_pkg::ST_TH_GO;
                    end
                end
            end
            vrpb_pkg::ST_PH_GO: begin
                cor_go    = 1'b1;
                cor_angle = r_pang;
                n_state   = vrpb_pkg::ST_PH_WAIT;
            end
            vrpb_pkg::ST_PH_WAIT: begin
                if (cor_res.done) begin
                    n_cp    = cor_res.cos_v;
                    n_sp    = cor_res.sin_v;
                    n_state = vrpb_pkg::ST_YSP;
                end
            end
            vrpb_pkg::ST_YSP: begin
                n_ysp   = DDW'(prod);
                n_t     = '0;
                n_state = vrpb_pkg::ST_TRD;
            end
            vrpb_pkg::ST_TRD: begin
                n_state = vrpb_pkg::ST_MU;
            end
            vrpb_pkg::ST_MU: begin
                n_u     = TRW'(prod >>> 30);
                n_state = vrpb_pkg::ST_MW;
            end
            vrpb_pkg::ST_MW: begin
                n_w     = TRW'(prod >>> 30);
                n_state = vrpb_pkg::ST_D1;
            end
            vrpb_pkg::ST_D1: begin
                n_d     = DDW'(prod) - r_ysp;
                n_state = vrpb_pkg::ST_D2;
            end
            vrpb_pkg::ST_D2: begin
                n_d     = r_d + DDW'(prod);
                n_state = vrpb_pkg::ST_BIN;
            end
            vrpb_pkg::ST_BIN, vrpb_pkg::ST_ACC: begin
                if ((r_state == vrpb_pkg::ST_BIN) && pbin_ok) begin
                    n_addr  = acc_addr;
                    n_state = vrpb_pkg::ST_ACC;
                end else begin
                    m_we = (r_state == vrpb_pkg::ST_ACC);
                    if (!last_t) begin
                        n_t     = r_t + TCW'(1);
                        n_state = vrpb_pkg::ST_TRD;
                    end else if (!last_f) begin
                        n_f     = r_f + FCW'(1);
                        n_pang  = f_ang_add(r_pang, pstep);
                        n_state = vrpb_pkg::ST_PH_GO;
                    end else begin
                        n_state = vrpb_pkg::ST_IDLE;
                    end
                end
            end
            vrpb_pkg::ST_RD_ISSUE: begin
                m_raddr = rd_addr;
                n_state = vrpb_pkg::ST_RD_DATA;
            end
            vrpb_pkg::ST_RD_DATA: begin
                n_valid         = 1'b1;
                n_res.bin_sum   = 48'(m_rdata);
                n_res.bad_index = 1'b0;
                n_state         = vrpb_pkg::ST_IDLE;
            end
            default: begin
                n_state = vrpb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vrpb_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_valid <= n_valid;
        end
        r_req  <= n_req;
        r_t    <= n_t;
        r_f    <= n_f;
        r_ang  <= n_ang;
        r_pang <= n_pang;
        r_cp   <= n_cp;
        r_sp   <= n_sp;
        r_u    <= n_u;
        r_w    <= n_w;
        r_d    <= n_d;
        r_ysp  <= n_ysp;
        r_addr <= n_addr;
        r_res  <= n_res;
    end

    assign busy    = (r_state != vrpb_pkg::ST_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
